FILE: hw/rtl/ffba_pkg.sv
// ffba_pkg: field widths, header codes, command codes and helper functions
// for the first-fit block allocator
// no dependencies
package ffba_pkg;

   localparam int CMD_W  = 2;
   localparam int SIZE_W = 20;
   localparam int SEG_W  = 16;
   localparam int HDR_W  = 23;
   localparam int SZ_W   = 21;
   localparam int CNT_W  = 16;
   localparam int FREE_W = 20;
   localparam int NXT_W  = 19;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_RESIZE = 2'd2,
      CMD_QUERY  = 2'd3
   } cmd_type;

   localparam logic [SEG_W-1:0]  BASE_PARA = 16'h1001;
   localparam logic [HDR_W-1:0]  HDR_TERM  = 23'h1;
   localparam logic [HDR_W-1:0]  HDR_FREE  = 23'h2;
   localparam logic [HDR_W-1:0]  HDR_STALE = 23'h3;
   localparam logic [SZ_W-1:0]   SIZE_MASK = 21'h1FFFFC;
   localparam logic [FREE_W-1:0] FREE_MAX  = 20'hFFFFF;

   // data size held in a header
   function automatic logic [SZ_W-1:0] hdr_size(input logic [HDR_W-1:0] h);
      return h[SZ_W-1:0] & SIZE_MASK;
   endfunction

   // paragraphs from this header to the next one, never zero
   function automatic logic [NXT_W-1:0] span_of(input logic [HDR_W-1:0] h);
      logic [SZ_W:0]    s;
      logic [NXT_W-1:0] k;
      s = {1'b0, hdr_size(h)} + (SZ_W+1)'(4);
      k = NXT_W'(s[SZ_W:4]);
      return (k == '0) ? NXT_W'(1) : k;
   endfunction

   // first part of a split, rounded so the next data stays paragraph aligned
   function automatic logic [SZ_W:0] round_head(input logic [SZ_W-1:0] want);
      logic [SZ_W:0] t;
      t = ({1'b0, want} + (SZ_W+1)'(19)) & ~(SZ_W+1)'(15);
      return t - (SZ_W+1)'(4);
   endfunction

   function automatic logic [FREE_W-1:0] sat_add(input logic [FREE_W-1:0] a,
                                                 input logic [SZ_W-1:0] b);
      logic [SZ_W:0] s;
      s = (SZ_W+1)'(a) + (SZ_W+1)'(b);
      return (s > (SZ_W+1)'(FREE_MAX)) ? FREE_MAX : s[FREE_W-1:0];
   endfunction

   function automatic logic [FREE_W-1:0] sat_sub(input logic [FREE_W-1:0] a,
                                                 input logic [SZ_W-1:0] b);
      logic [SZ_W-1:0] d;
      d = SZ_W'(a) - b;
      return (SZ_W'(a) < b) ? '0 : d[FREE_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/ffba_ifs.sv
// ffba_ifs: valid/ready channels for request and response words
// depends on ffba_pkg
interface ffba_req_if;
   import ffba_pkg::*;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [SIZE_W-1:0] size_bytes;
   logic [SEG_W-1:0]  segment;
   modport source (output valid, cmd, size_bytes, segment, input ready);
   modport sink   (input valid, cmd, size_bytes, segment, output ready);
endinterface

interface ffba_rsp_if;
   import ffba_pkg::*;
   logic              valid;
   logic              ready;
   logic              ok;
   logic [SEG_W-1:0]  result_segment;
   logic              moved;
   logic [SIZE_W-1:0] copy_bytes;
   logic [SIZE_W-1:0] largest_free;
   logic [CNT_W-1:0]  blocks_in_use;
   logic [FREE_W-1:0] free_bytes;
   modport source (output valid, ok, result_segment, moved, copy_bytes, largest_free,
                   blocks_in_use, free_bytes, input ready);
   modport sink   (input valid, ok, result_segment, moved, copy_bytes, largest_free,
                   blocks_in_use, free_bytes, output ready);
endinterface

FILE: hw/rtl/ffba_ram.sv
// ffba_ram: generic simple dual-port RAM, one write and one registered read
// no dependencies
module ffba_ram #(
   parameter int WIDTH = 23,
   parameter int DEPTH = 36864
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule

FILE: hw/rtl/first_fit_block_allocator.sv
// first_fit_block_allocator: first-fit allocator with free block merging over
// a header memory; depends on ffba_pkg, ffba_ifs and ffba_ram
// flow: the walk reads one header at a time; a free block also reads the
//   header after it, merging each free neighbour until a used one or the
//   arena end, then settles; the block is then split, counters updated
//   and the response loaded; an alloc, query or growing resize walks from
//   the first block to a fit or the terminal, bounded by the arena size
// throughput: one command at a time, a request word is taken only in idle
// reset: a clearing pass writes every header before the first request word
//   is taken
module first_fit_block_allocator #(
   parameter int ARENA_PARAGRAPHS = 36864,
   parameter int SPLIT_SLACK      = 32
) (
   input  logic       clock,
   input  logic       reset,
   ffba_req_if.sink   req_chan,
   ffba_rsp_if.source rsp_chan
);
   import ffba_pkg::*;

   localparam int AW = $clog2(ARENA_PARAGRAPHS);
   localparam logic [AW-1:0]    LAST_IDX  = AW'(ARENA_PARAGRAPHS - 1);
   localparam logic [NXT_W-1:0] ARENA_N   = NXT_W'(ARENA_PARAGRAPHS);
   localparam logic [SZ_W-1:0]  ROOT_SIZE = SZ_W'((ARENA_PARAGRAPHS - 1) * 16 - 4) & SIZE_MASK;
   localparam logic [FREE_W-1:0] FREE_RESET =
      (ROOT_SIZE > SZ_W'(FREE_MAX)) ? FREE_MAX : ROOT_SIZE[FREE_W-1:0];
   localparam logic [SZ_W-1:0]  SLACK = SZ_W'(SPLIT_SLACK);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_LIVE_HD, ST_WALK_RD, ST_WALK_HD, ST_MRG_RD, ST_MRG_HD,
      ST_MRG_END, ST_CARVE, ST_CARVE_HI, ST_FINISH, ST_RSZ_FREE, ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      FIN_ALLOC, FIN_RSZ_IN, FIN_RSZ_MOVE, FIN_RSZ_FAIL
   } fin_type;

   state_type        state_ff, state_in;
   fin_type          fin_ff, fin_in;
   cmd_type          cmd_ff, cmd_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SEG_W-1:0] seg_ff, seg_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic [SZ_W-1:0]  org_ff, org_in;
   logic [SZ_W-1:0]  bsold_ff, bsold_in;
   logic             phase2_ff, phase2_in;
   logic [NXT_W-1:0] walk_ff, walk_in;
   logic [AW-1:0]    base_ff, base_in;
   logic [HDR_W-1:0] cur_ff, cur_in;
   logic [AW-1:0]    nxt_ff, nxt_in;
   logic [SZ_W-1:0]  best_ff, best_in;
   logic [AW-1:0]    cbase_ff, cbase_in;
   logic [SZ_W-1:0]  cbs_ff, cbs_in;
   logic [SZ_W-1:0]  cwant_ff, cwant_in;
   logic [SZ_W-1:0]  ns_ff, ns_in;
   logic [AW-1:0]    chi_addr_ff, chi_addr_in;
   logic [HDR_W-1:0] chi_data_ff, chi_data_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [FREE_W-1:0] ftot_ff, ftot_in;
   logic             res_ok_ff, res_ok_in;
   logic [SEG_W-1:0] res_seg_ff, res_seg_in;
   logic             res_moved_ff, res_moved_in;
   logic [SIZE_W-1:0] res_copy_ff, res_copy_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_ok_ff, out_ok_in;
   logic [SEG_W-1:0] out_seg_ff, out_seg_in;
   logic             out_moved_ff, out_moved_in;
   logic [SIZE_W-1:0] out_copy_ff, out_copy_in;
   logic [SIZE_W-1:0] out_large_ff, out_large_in;
   logic [CNT_W-1:0] out_count_ff, out_count_in;
   logic [FREE_W-1:0] out_free_ff, out_free_in;

   logic             ram_we, ram_re;
   logic [AW-1:0]    ram_waddr, ram_raddr;
   logic [HDR_W-1:0] ram_wdata, ram_rdata;

   // request decode
   logic             req_fire;
   cmd_type          req_cmd;
   logic [SEG_W-1:0] req_off;
   logic             req_live_ok;
   logic [SZ_W-1:0]  req_size21;

   // merge, carve and walk helpers
   logic [NXT_W-1:0] mrg_next;
   logic [SZ_W-1:0]  mrg_size;
   logic [SZ_W-1:0]  cur_bs;
   logic [SZ_W:0]    cv_head;
   logic [SZ_W:0]    cv_head_p4;
   logic [SZ_W-1:0]  cv_diff;
   logic             cv_split;
   logic [NXT_W-1:0] cv_next;
   logic [SZ_W-1:0]  cv_rest;

   assign req_fire    = req_chan.valid && req_chan.ready;
   assign req_cmd     = cmd_type'(req_chan.cmd);
   assign req_off     = req_chan.segment - BASE_PARA;
   assign req_live_ok = (req_chan.segment >= BASE_PARA) &&
                        ((SEG_W+1)'(req_off) < (SEG_W+1)'(LAST_IDX));
   assign req_size21  = SZ_W'(req_chan.size_bytes);

   assign cur_bs   = hdr_size(cur_ff);
   assign mrg_next = NXT_W'(base_ff) + span_of(cur_ff);
   assign mrg_size = (cur_bs + SZ_W'(4) + hdr_size(ram_rdata)) & SIZE_MASK;

   assign cv_head    = round_head(cwant_ff);
   assign cv_head_p4 = cv_head + (SZ_W+1)'(4);
   assign cv_diff    = cbs_ff - cwant_ff;
   assign cv_split   = (cv_diff > SLACK) && (cv_head < {1'b0, cbs_ff});
   assign cv_next    = NXT_W'(cbase_ff) + NXT_W'(cv_head_p4[SZ_W:4]);
   assign cv_rest    = (cbs_ff - cv_head[SZ_W-1:0] - SZ_W'(4)) & SIZE_MASK;

   ffba_ram #(.WIDTH(HDR_W), .DEPTH(ARENA_PARAGRAPHS)) u_hdr_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.ok             = out_ok_ff;
   assign rsp_chan.result_segment = out_seg_ff;
   assign rsp_chan.moved          = out_moved_ff;
   assign rsp_chan.copy_bytes     = out_copy_ff;
   assign rsp_chan.largest_free   = out_large_ff;
   assign rsp_chan.blocks_in_use  = out_count_ff;
   assign rsp_chan.free_bytes     = out_free_ff;

   // command sequencer
   always_comb begin
      state_in     = state_ff;
      fin_in       = fin_ff;
      cmd_in       = cmd_ff;
      clr_in       = clr_ff;
      size_in      = size_ff;
      seg_in       = seg_ff;
      idx_in       = idx_ff;
      org_in       = org_ff;
      bsold_in     = bsold_ff;
      phase2_in    = phase2_ff;
      walk_in      = walk_ff;
      base_in      = base_ff;
      cur_in       = cur_ff;
      nxt_in       = nxt_ff;
      best_in      = best_ff;
      cbase_in     = cbase_ff;
      cbs_in       = cbs_ff;
      cwant_in     = cwant_ff;
      ns_in        = ns_ff;
      chi_addr_in  = chi_addr_ff;
      chi_data_in  = chi_data_ff;
      count_in     = count_ff;
      ftot_in      = ftot_ff;
      res_ok_in    = res_ok_ff;
      res_seg_in   = res_seg_ff;
      res_moved_in = res_moved_ff;
      res_copy_in  = res_copy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      out_ok_in    = out_ok_ff;
      out_seg_in   = out_seg_ff;
      out_moved_in = out_moved_ff;
      out_copy_in  = out_copy_ff;
      out_large_in = out_large_ff;
      out_count_in = out_count_ff;
      out_free_in  = out_free_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = '0;

      case (state_ff)
         // write the reset image of every header
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            if (clr_ff == '0) begin
               ram_wdata = HDR_W'(ROOT_SIZE) | HDR_FREE;
            end else if (clr_ff == LAST_IDX) begin
               ram_wdata = HDR_TERM;
            end else begin
               ram_wdata = HDR_STALE;
            end
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end

         // take a request word
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in       = req_cmd;
               size_in      = req_chan.size_bytes;
               seg_in       = req_chan.segment;
               idx_in       = req_off[AW-1:0];
               res_ok_in    = 1'b0;
               res_seg_in   = '0;
               res_moved_in = 1'b0;
               res_copy_in  = '0;
               best_in      = '0;
               phase2_in    = 1'b0;
               walk_in      = '0;
               case (req_cmd)
                  CMD_ALLOC: begin
                     state_in = (req_chan.size_bytes > ftot_ff) ? ST_RESP : ST_WALK_RD;
                  end
                  CMD_QUERY: begin
                     state_in = ST_WALK_RD;
                  end
                  default: begin
                     if (req_live_ok) begin
                        ram_re    = 1'b1;
                        ram_raddr = req_off[AW-1:0];
                        state_in  = ST_LIVE_HD;
                     end else begin
                        state_in = ST_RESP;
                     end
                  end
               endcase
            end
         end

         // header of the block named by free or resize
         ST_LIVE_HD: begin
            if (ram_rdata[1:0] != 2'b00) begin
               state_in = ST_RESP;
            end else if (cmd_ff == CMD_FREE) begin
               count_in  = count_ff - CNT_W'(1);
               ftot_in   = sat_add(ftot_ff, hdr_size(ram_rdata));
               ram_we    = 1'b1;
               ram_waddr = idx_ff;
               ram_wdata = ram_rdata | HDR_FREE;
               res_ok_in = 1'b1;
               state_in  = ST_RESP;
            end else begin
               org_in   = hdr_size(ram_rdata);
               cur_in   = ram_rdata;
               base_in  = idx_ff;
               state_in = ST_MRG_RD;
            end
         end

         // walk: fetch the next header or finish
         ST_WALK_RD: begin
            if (walk_ff >= ARENA_N) begin
               if (cmd_ff == CMD_QUERY) begin
                  res_ok_in = 1'b1;
                  state_in  = ST_RESP;
               end else if (cmd_ff == CMD_RESIZE) begin
                  cbase_in = idx_ff;
                  cbs_in   = bsold_ff;
                  cwant_in = org_ff;
                  fin_in   = FIN_RSZ_FAIL;
                  state_in = ST_CARVE;
               end else begin
                  state_in = ST_RESP;
               end
            end else begin
               ram_re    = 1'b1;
               ram_raddr = walk_ff[AW-1:0];
               state_in  = ST_WALK_HD;
            end
         end

         ST_WALK_HD: begin
            if (ram_rdata == HDR_TERM) begin
               walk_in  = ARENA_N;
               state_in = ST_WALK_RD;
            end else if (ram_rdata[1]) begin
               cur_in   = ram_rdata;
               base_in  = walk_ff[AW-1:0];
               state_in = ST_MRG_RD;
            end else begin
               walk_in  = walk_ff + span_of(ram_rdata);
               state_in = ST_WALK_RD;
            end
         end

         // merge: fetch the header after the current block
         ST_MRG_RD: begin
            if (mrg_next >= ARENA_N) begin
               state_in = ST_MRG_END;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = mrg_next[AW-1:0];
               nxt_in    = mrg_next[AW-1:0];
               state_in  = ST_MRG_HD;
            end
         end

         ST_MRG_HD: begin
            if (ram_rdata[1]) begin
               cur_in    = (cur_ff & ~HDR_W'(SIZE_MASK)) | HDR_W'(mrg_size);
               ram_we    = 1'b1;
               ram_waddr = nxt_ff;
               ram_wdata = HDR_STALE;
               state_in  = ST_MRG_RD;
            end else begin
               state_in = ST_MRG_END;
            end
         end

         // merged block is final: fit, record or move on
         ST_MRG_END: begin
            cbase_in = base_ff;
            cbs_in   = cur_bs;
            cwant_in = SZ_W'(size_ff);
            if (cmd_ff == CMD_RESIZE && !phase2_ff) begin
               if (cur_bs >= SZ_W'(size_ff)) begin
                  fin_in   = FIN_RSZ_IN;
                  state_in = ST_CARVE;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = base_ff;
                  ram_wdata = cur_ff;
                  bsold_in  = cur_bs;
                  phase2_in = 1'b1;
                  walk_in   = '0;
                  if (size_ff > ftot_ff) begin
                     cwant_in = org_ff;
                     fin_in   = FIN_RSZ_FAIL;
                     state_in = ST_CARVE;
                  end else begin
                     state_in = ST_WALK_RD;
                  end
               end
            end else if (cmd_ff == CMD_QUERY) begin
               if (cur_bs > best_ff) begin
                  best_in = cur_bs;
               end
               ram_we    = 1'b1;
               ram_waddr = base_ff;
               ram_wdata = cur_ff;
               walk_in   = mrg_next;
               state_in  = ST_WALK_RD;
            end else if (cur_bs >= SZ_W'(size_ff)) begin
               fin_in   = (cmd_ff == CMD_RESIZE) ? FIN_RSZ_MOVE : FIN_ALLOC;
               state_in = ST_CARVE;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = base_ff;
               ram_wdata = cur_ff;
               walk_in   = mrg_next;
               state_in  = ST_WALK_RD;
            end
         end

         // size the block and split off the slack
         ST_CARVE: begin
            ram_we    = 1'b1;
            ram_waddr = cbase_ff;
            if (cv_split) begin
               ram_wdata   = HDR_W'(cv_head);
               ns_in       = cv_head[SZ_W-1:0];
               chi_addr_in = cv_next[AW-1:0];
               chi_data_in = HDR_W'(cv_rest) | HDR_FREE;
               state_in    = (cv_next < ARENA_N) ? ST_CARVE_HI : ST_FINISH;
            end else begin
               ram_wdata = HDR_W'(cbs_ff);
               ns_in     = cbs_ff;
               state_in  = ST_FINISH;
            end
         end

         ST_CARVE_HI: begin
            ram_we    = 1'b1;
            ram_waddr = chi_addr_ff;
            ram_wdata = chi_data_ff;
            state_in  = ST_FINISH;
         end

         // counters and result after a carve
         ST_FINISH: begin
            case (fin_ff)
               FIN_ALLOC: begin
                  count_in   = count_ff + CNT_W'(1);
                  ftot_in    = sat_sub(ftot_ff, ns_ff);
                  res_ok_in  = 1'b1;
                  res_seg_in = BASE_PARA + SEG_W'(cbase_ff);
                  state_in   = ST_RESP;
               end
               FIN_RSZ_IN: begin
                  if (org_ff >= ns_ff) begin
                     ftot_in = sat_add(ftot_ff, org_ff - ns_ff);
                  end else begin
                     ftot_in = sat_sub(ftot_ff, ns_ff - org_ff);
                  end
                  res_ok_in  = 1'b1;
                  res_seg_in = seg_ff;
                  state_in   = ST_RESP;
               end
               FIN_RSZ_MOVE: begin
                  count_in   = count_ff + CNT_W'(1);
                  ftot_in    = sat_sub(ftot_ff, ns_ff);
                  res_seg_in = BASE_PARA + SEG_W'(cbase_ff);
                  state_in   = ST_RSZ_FREE;
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end

         // release the old block after a relocation
         ST_RSZ_FREE: begin
            count_in     = count_ff - CNT_W'(1);
            ftot_in      = sat_add(ftot_ff, org_ff);
            ram_we       = 1'b1;
            ram_waddr    = idx_ff;
            ram_wdata    = HDR_W'(bsold_ff) | HDR_FREE;
            res_ok_in    = 1'b1;
            res_moved_in = 1'b1;
            res_copy_in  = (SZ_W'(size_ff) < org_ff) ? size_ff : org_ff[SIZE_W-1:0];
            state_in     = ST_RESP;
         end

         // load the response word once the output slot is free
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               out_ok_in    = res_ok_ff;
               out_seg_in   = res_seg_ff;
               out_moved_in = res_moved_ff;
               out_copy_in  = res_copy_ff;
               out_large_in = (cmd_ff == CMD_QUERY) ? best_ff[SIZE_W-1:0] : '0;
               out_count_in = count_ff;
               out_free_in  = ftot_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         ftot_ff      <= FREE_RESET;
         rsp_valid_ff <= 1'b0;
         phase2_ff    <= 1'b0;
         fin_ff       <= FIN_ALLOC;
         cmd_ff       <= CMD_ALLOC;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         ftot_ff      <= ftot_in;
         rsp_valid_ff <= rsp_valid_in;
         phase2_ff    <= phase2_in;
         fin_ff       <= fin_in;
         cmd_ff       <= cmd_in;
      end
      size_ff      <= size_in;
      seg_ff       <= seg_in;
      idx_ff       <= idx_in;
      org_ff       <= org_in;
      bsold_ff     <= bsold_in;
      walk_ff      <= walk_in;
      base_ff      <= base_in;
      cur_ff       <= cur_in;
      nxt_ff       <= nxt_in;
      best_ff      <= best_in;
      cbase_ff     <= cbase_in;
      cbs_ff       <= cbs_in;
      cwant_ff     <= cwant_in;
      ns_ff        <= ns_in;
      chi_addr_ff  <= chi_addr_in;
      chi_data_ff  <= chi_data_in;
      res_ok_ff    <= res_ok_in;
      res_seg_ff   <= res_seg_in;
      res_moved_ff <= res_moved_in;
      res_copy_ff  <= res_copy_in;
      out_ok_ff    <= out_ok_in;
      out_seg_ff   <= out_seg_in;
      out_moved_ff <= out_moved_in;
      out_copy_ff  <= out_copy_in;
      out_large_ff <= out_large_in;
      out_count_ff <= out_count_in;
      out_free_ff  <= out_free_in;
   end

   // checks
   a_no_rw_same_cycle: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re && (ram_waddr == ram_raddr)))
      else $error("header read and write hit the same entry");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + CNT_W'(1)) ||
      (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("block count moved by more than one");

   a_resp_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && state_in == ST_IDLE) |=> rsp_valid_ff)
      else $error("command finished without a response word");

endmodule
